/* rtl/sps_pkg.sv */
// Shared constants for the double SHA-1 scramble token block.
`default_nettype none
package sps_pkg;
	localparam int TOKEN_BYTES = 20;
	localparam int CMD_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 5;

	localparam logic [CMD_W-1:0] CMD_SALT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PASS = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

	localparam logic [159:0] SHA_INIT = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};
endpackage
`default_nettype wire

/* rtl/sps_cmd_if.sv */
// Command channel: salt bytes, password bytes and the end command.
`default_nettype none
interface sps_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [sps_pkg::CMD_W-1:0]     command;
	logic [sps_pkg::BYTE_W-1:0]    data_byte;
	modport source(output valid, command, data_byte, input ready);
	modport sink(input valid, command, data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/sps_tok_if.sv */
// Token channel: one scramble token byte per transfer.
`default_nettype none
interface sps_tok_if;
	logic                          valid;
	logic                          ready;
	logic [sps_pkg::BYTE_W-1:0]    token_byte;
	logic [sps_pkg::IDX_W-1:0]     byte_index;
	logic                          last_byte;
	modport source(output valid, token_byte, byte_index, last_byte, input ready);
	modport sink(input valid, token_byte, byte_index, last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/sha1_password_scramble_token.sv */
// Double SHA-1 challenge scramble token unit, one SHA-1 round per cycle.
// Salt and password bytes are taken while idle; a password byte that closes a
// 64-byte block starts a compression (load, 80 rounds, chain add). The end
// command runs three hashes through the same round unit: feeding and padding
// one byte per cycle, held while each full 64-byte block is compressed, then
// 20 token byte transfers. The command channel is not ready from the end
// command until the last token byte is taken. The round unit keeps its
// message words in a 16-word schedule shift register.
`default_nettype none
module sha1_password_scramble_token (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sps_cmd_if.sink     cmd,
	sps_tok_if.source   tok
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PAD   = 4'd1;
	localparam logic [3:0] S_LEN   = 4'd2;
	localparam logic [3:0] S_FEED  = 4'd3;
	localparam logic [3:0] S_CLOAD = 4'd4;
	localparam logic [3:0] S_CRND  = 4'd5;
	localparam logic [3:0] S_CADD  = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam logic [1:0] PH_PASS = 2'd0;
	localparam logic [1:0] PH_S1   = 2'd1;
	localparam logic [1:0] PH_T    = 2'd2;

	logic [3:0]   state_q, ret_q, aft_state;
	logic [1:0]   phase_q;
	logic [63:0]  len_q, bitlen_q, len_next;
	logic [5:0]   cnt_q;
	logic [6:0]   rnd_q;
	logic [4:0]   oidx_q, salt_cnt_q, fidx;
	logic         pad_first_q;
	logic [159:0] h_q, s1_q, s2_q;
	logic [31:0]  blk_q [16];
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [7:0]   salt_q [sps_pkg::TOKEN_BYTES];

	logic         cmd_xfer, tok_xfer, abs_en, blk_full, feed_last;
	logic [7:0]   abs_byte;
	logic [5:0]   pos;
	logic [31:0]  f_r, k_r, tmp_r, w_new;

	function automatic logic [7:0] dig_byte(input logic [159:0] v, input logic [4:0] k);
		logic [4:0] r;
		r = 5'd19 - k;
		return v[{r, 3'b000} +: 8];
	endfunction

	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign tok_xfer  = tok.valid && tok.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign tok.valid = (state_q == S_OUT);
	assign tok.token_byte = dig_byte(h_q, oidx_q) ^ dig_byte(s1_q, oidx_q);
	assign tok.byte_index = oidx_q;
	assign tok.last_byte  = (oidx_q == 5'd19);

	assign pos       = len_q[5:0];
	assign len_next  = len_q + 64'd1;
	assign blk_full  = (pos == 6'd63);
	assign fidx      = (cnt_q < 6'd20) ? cnt_q[4:0] : 5'(cnt_q - 6'd20);
	assign feed_last = (phase_q == PH_S1) ? (cnt_q == 6'd19) : (cnt_q == 6'd39);

	always_comb begin
		abs_en    = 1'b0;
		abs_byte  = 8'h00;
		aft_state = state_q;
		case (state_q)
			S_IDLE: begin
				abs_en    = cmd_xfer && (cmd.command == sps_pkg::CMD_PASS);
				abs_byte  = cmd.data_byte;
				aft_state = S_IDLE;
			end
			S_PAD: begin
				abs_en    = 1'b1;
				abs_byte  = pad_first_q ? 8'h80 : 8'h00;
				aft_state = (len_next[5:0] == 6'd56) ? S_LEN : S_PAD;
			end
			S_LEN: begin
				abs_en    = 1'b1;
				abs_byte  = bitlen_q[{~cnt_q[2:0], 3'b000} +: 8];
				aft_state = (cnt_q[2:0] == 3'd7) ? S_FIN : S_LEN;
			end
			S_FEED: begin
				abs_en = 1'b1;
				if (phase_q == PH_S1 || cnt_q < 6'd20) begin
					abs_byte = (phase_q == PH_S1) ? dig_byte(s1_q, fidx) : salt_q[fidx];
				end else begin
					abs_byte = dig_byte(s2_q, fidx);
				end
				aft_state = feed_last ? S_PAD : S_FEED;
			end
			default: begin
				abs_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_r = (b_q & c_q) | (~b_q & d_q);
			k_r = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f_r = b_q ^ c_q ^ d_q;
			k_r = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f_r = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_r = 32'h8F1BBCDC;
		end else begin
			f_r = b_q ^ c_q ^ d_q;
			k_r = 32'hCA62C1D6;
		end
		tmp_r = {a_q[26:0], a_q[31:27]} + f_r + e_q + k_r + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			phase_q     <= PH_PASS;
			len_q       <= '0;
			bitlen_q    <= '0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			salt_cnt_q  <= '0;
			pad_first_q <= 1'b0;
			h_q         <= sps_pkg::SHA_INIT;
		end else begin
			if (abs_en) begin
				len_q <= len_next;
				if (blk_full) begin
					state_q <= S_CLOAD;
					ret_q   <= aft_state;
				end else begin
					state_q <= aft_state;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_xfer && cmd.command == sps_pkg::CMD_SALT &&
						salt_cnt_q < 5'(sps_pkg::TOKEN_BYTES)) begin
						salt_cnt_q <= salt_cnt_q + 5'd1;
					end
					if (cmd_xfer && cmd.command == sps_pkg::CMD_END) begin
						bitlen_q    <= {len_q[60:0], 3'b000};
						pad_first_q <= 1'b1;
						phase_q     <= PH_PASS;
						state_q     <= S_PAD;
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					cnt_q       <= '0;
				end
				S_LEN: begin
					cnt_q <= cnt_q + 6'd1;
				end
				S_FEED: begin
					cnt_q <= cnt_q + 6'd1;
					if (feed_last) begin
						bitlen_q    <= {len_next[60:0], 3'b000};
						pad_first_q <= 1'b1;
					end
				end
				S_CLOAD: begin
					rnd_q   <= '0;
					state_q <= S_CRND;
				end
				S_CRND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						state_q <= S_CADD;
					end
				end
				S_CADD: begin
					h_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
						h_q[63:32] + d_q, h_q[31:0] + e_q};
					state_q <= ret_q;
				end
				S_FIN: begin
					cnt_q <= '0;
					if (phase_q == PH_T) begin
						oidx_q  <= '0;
						state_q <= S_OUT;
					end else begin
						h_q     <= sps_pkg::SHA_INIT;
						len_q   <= '0;
						phase_q <= (phase_q == PH_PASS) ? PH_S1 : PH_T;
						state_q <= S_FEED;
					end
				end
				S_OUT: begin
					if (tok_xfer) begin
						oidx_q <= oidx_q + 5'd1;
						if (oidx_q == 5'd19) begin
							h_q        <= sps_pkg::SHA_INIT;
							len_q      <= '0;
							salt_cnt_q <= '0;
							phase_q    <= PH_PASS;
							state_q    <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (abs_en) begin
			blk_q[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= abs_byte;
		end
		if (state_q == S_IDLE && cmd_xfer && cmd.command == sps_pkg::CMD_SALT &&
			salt_cnt_q < 5'(sps_pkg::TOKEN_BYTES)) begin
			salt_q[salt_cnt_q] <= cmd.data_byte;
		end
		if (state_q == S_FIN && phase_q == PH_PASS) begin
			s1_q <= h_q;
		end
		if (state_q == S_FIN && phase_q == PH_S1) begin
			s2_q <= h_q;
		end
		if (state_q == S_CLOAD) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_q[i];
			end
			a_q <= h_q[159:128];
			b_q <= h_q[127:96];
			c_q <= h_q[95:64];
			d_q <= h_q[63:32];
			e_q <= h_q[31:0];
		end
		if (state_q == S_CRND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			a_q <= tmp_r;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end
endmodule
`default_nettype wire
